### rtl/ces_pkg.sv
// ----------------------------------------------------------------------------
// ces_pkg
// shared types, codes and helpers of the channel entitlement sync block
// ----------------------------------------------------------------------------
`default_nettype none

package ces_pkg;

    localparam int IDX_W         = 13;
    localparam int BYTE_W        = 8;
    localparam int CH_W          = 16;
    localparam int KIND_W        = 2;
    localparam int MAP_BYTES_DEF = 8192;

    // byte that holds the highest channel, which is never entitled
    localparam logic [IDX_W-1:0] TOP_IDX = 13'h1FFF;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUM = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QRY = 2'd3;

    // item function codes
    localparam logic FUNC_SYNC  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] bitmap_byte;
        logic              end_of_sync;
        logic [BYTE_W-1:0] access_flags;
        logic [CH_W-1:0]   query_channel;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CH_W-1:0]   channel;
        logic              entitled;
        logic              list_changed;
        logic              flags_changed;
        logic              last;
    } result_t;

    // write port of the map memory
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } map_wr_t;

    // channel 0 and the top channel can never be set
    function automatic logic [BYTE_W-1:0] legal_bits(
        input logic [IDX_W-1:0]  idx,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] r;
        r = b;
        if (idx == '0)
        begin
            r[0] = 1'b0;
        end
        if (idx == TOP_IDX)
        begin
            r[BYTE_W-1] = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/ces_ifs.sv
// ----------------------------------------------------------------------------
// ces_ifs
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface ces_item_if;
    logic           valid;
    logic           ready;
    ces_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ces_result_if;
    logic             valid;
    logic             ready;
    ces_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/channel_entitlement_sync.sv
// ----------------------------------------------------------------------------
// channel_entitlement_sync
// entitlement bitmap with per-bit change events, sync summary and queries
// ----------------------------------------------------------------------------
// item flow: the item is registered on its transaction, its map byte is
//   read and, for a sync item, written back in the read state, then each
//   result it causes (0 to 9) gets one output load, longer while the
//   result channel holds off; no new item is taken until the last is loaded
// reset: once rst_n is released a sweep zeroes all MAP_BYTES map bytes,
//   one byte per cycle, with item ready held low during the sweep
// ----------------------------------------------------------------------------
`default_nettype none

module channel_entitlement_sync #(
    parameter int MAP_BYTES = ces_pkg::MAP_BYTES_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ces_item_if.sink     item_ch,
    ces_result_if.source result_ch
);

    // map address width follows the map size
    localparam int AW = $clog2(MAP_BYTES);

    // memory write port from the sequencer, read data back from the memory
    ces_pkg::map_wr_t             map_wr;
    logic [AW-1:0]                map_raddr;
    logic [ces_pkg::BYTE_W-1:0]   map_rdata;

    // bitmap storage, read data is registered and arrives in the cycle after the address
    ces_map_ram #(
        .MAP_BYTES (MAP_BYTES),
        .AW        (AW)
    ) u_map_ram (
        .clk       (clk),
        .map_wr    (map_wr),
        .raddr     (map_raddr),
        .rdata_reg (map_rdata)
    );

    // sequencer: sweep, read on accept, compare and write back, then one
    // result transaction per changed bit in ascending channel order and an
    // optional summary, or the query answer
    ces_seq #(
        .MAP_BYTES (MAP_BYTES),
        .AW        (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch),
        .map_wr    (map_wr),
        .map_raddr (map_raddr),
        .map_rdata (map_rdata)
    );

endmodule

`default_nettype wire

### rtl/ces_map_ram.sv
// ----------------------------------------------------------------------------
// ces_map_ram
// entitlement bitmap storage, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ces_map_ram #(
    parameter int MAP_BYTES = ces_pkg::MAP_BYTES_DEF,
    parameter int AW        = $clog2(MAP_BYTES)
) (
    input  wire logic                       clk,
    input  wire ces_pkg::map_wr_t           map_wr,
    input  wire logic [AW-1:0]              raddr,
    output logic [ces_pkg::BYTE_W-1:0]      rdata_reg
);

    logic [ces_pkg::BYTE_W-1:0] mem [MAP_BYTES];

    always_ff @(posedge clk)
    begin
        if (map_wr.we)
        begin
            mem[map_wr.addr[AW-1:0]] <= map_wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/ces_seq.sv
// ----------------------------------------------------------------------------
// ces_seq
// sequencer: clearing sweep, read-modify-write of map bytes, event emission
// ----------------------------------------------------------------------------
`default_nettype none

module ces_seq #(
    parameter int MAP_BYTES = ces_pkg::MAP_BYTES_DEF,
    parameter int AW        = $clog2(MAP_BYTES)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    ces_item_if.sink                        item_ch,
    ces_result_if.source                    result_ch,
    output ces_pkg::map_wr_t                map_wr,
    output logic [AW-1:0]                   map_raddr,
    input  wire logic [ces_pkg::BYTE_W-1:0] map_rdata
);

    localparam int LIM_W = ces_pkg::IDX_W + 1;
    localparam logic [LIM_W-1:0] MAP_LIMIT = LIM_W'(MAP_BYTES);
    localparam logic [AW-1:0]    CLR_END   = AW'(MAP_BYTES - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // lowest set bit of a byte
    function automatic logic [2:0] low_bit(input logic [ces_pkg::BYTE_W-1:0] b);
        logic [2:0] j;
        j = 3'd0;
        for (int i = ces_pkg::BYTE_W - 1; i >= 0; i--)
        begin
            if (b[i])
            begin
                j = 3'(i);
            end
        end
        return j;
    endfunction

    logic [1:0]                  state_reg, state_next;
    logic [AW-1:0]               clr_cnt_reg, clr_cnt_next;
    ces_pkg::item_t              item_reg, item_next;
    logic [ces_pkg::BYTE_W-1:0]  diff_reg, diff_next;
    logic                        qry_pend_reg, qry_pend_next;
    logic                        sum_pend_reg, sum_pend_next;
    logic                        ent_reg, ent_next;
    logic [ces_pkg::BYTE_W-1:0]  flags_reg, flags_next;
    logic                        pass_changed_reg, pass_changed_next;
    logic                        out_valid_reg, out_valid_next;
    ces_pkg::result_t            out_item_reg, out_item_next;

    logic [ces_pkg::IDX_W-1:0]   sel_idx;
    logic [ces_pkg::IDX_W-1:0]   qry_idx;
    logic                        sync_in_range;
    logic                        qry_in_range;
    logic [ces_pkg::BYTE_W-1:0]  new_byte;
    logic [ces_pkg::BYTE_W-1:0]  old_legal;
    logic [ces_pkg::BYTE_W-1:0]  rd_diff;
    logic [ces_pkg::BYTE_W-1:0]  rem_diff;
    logic [2:0]                  bit_sel;
    logic                        out_free;

    // address of the byte an incoming item touches
    assign sel_idx   = (item_ch.data.func == ces_pkg::FUNC_QUERY)
                       ? item_ch.data.query_channel[ces_pkg::CH_W-1:3]
                       : item_ch.data.byte_index;
    assign map_raddr = sel_idx[AW-1:0];

    assign qry_idx       = item_reg.query_channel[ces_pkg::CH_W-1:3];
    assign sync_in_range = {1'b0, item_reg.byte_index} < MAP_LIMIT;
    assign qry_in_range  = {1'b0, qry_idx} < MAP_LIMIT;
    assign new_byte      = ces_pkg::legal_bits(item_reg.byte_index, item_reg.bitmap_byte);
    assign old_legal     = ces_pkg::legal_bits(qry_idx, map_rdata);
    assign rd_diff       = sync_in_range ? (map_rdata ^ new_byte) : '0;
    assign bit_sel       = low_bit(diff_reg);
    assign rem_diff      = diff_reg & ~(ces_pkg::BYTE_W'(1) << bit_sel);
    assign out_free      = !out_valid_reg || result_ch.ready;

    assign item_ch.ready   = (state_reg == ST_IDLE);
    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_item_reg;

    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        item_next         = item_reg;
        diff_next         = diff_reg;
        qry_pend_next     = qry_pend_reg;
        sum_pend_next     = sum_pend_reg;
        ent_next          = ent_reg;
        flags_next        = flags_reg;
        pass_changed_next = pass_changed_reg;
        out_valid_next    = out_valid_reg && !result_ch.ready;
        out_item_next     = out_item_reg;
        map_wr            = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                map_wr.we    = 1'b1;
                map_wr.addr  = ces_pkg::IDX_W'(clr_cnt_reg);
                map_wr.data  = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == CLR_END)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_ch.valid)
                begin
                    item_next  = item_ch.data;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (item_reg.func == ces_pkg::FUNC_QUERY)
                begin
                    qry_pend_next = 1'b1;
                    sum_pend_next = 1'b0;
                    diff_next     = '0;
                    ent_next      = qry_in_range
                                    && old_legal[item_reg.query_channel[2:0]];
                    state_next    = ST_EMIT;
                end
                else
                begin
                    qry_pend_next = 1'b0;
                    sum_pend_next = item_reg.end_of_sync;
                    diff_next     = rd_diff;
                    map_wr.we     = sync_in_range;
                    map_wr.addr   = item_reg.byte_index;
                    map_wr.data   = new_byte;
                    if (rd_diff != '0)
                    begin
                        pass_changed_next = 1'b1;
                    end
                    if ((rd_diff != '0) || item_reg.end_of_sync)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '0;
                    if (qry_pend_reg)
                    begin
                        out_item_next.kind     = ces_pkg::KIND_QRY;
                        out_item_next.channel  = item_reg.query_channel;
                        out_item_next.entitled = ent_reg;
                        out_item_next.last     = 1'b1;
                        qry_pend_next          = 1'b0;
                        state_next             = ST_IDLE;
                    end
                    else if (diff_reg != '0)
                    begin
                        out_item_next.kind    = new_byte[bit_sel] ? ces_pkg::KIND_ADD
                                                                  : ces_pkg::KIND_DEL;
                        out_item_next.channel = {item_reg.byte_index, bit_sel};
                        out_item_next.last    = (rem_diff == '0) && !sum_pend_reg;
                        diff_next             = rem_diff;
                        if ((rem_diff == '0) && !sum_pend_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        out_item_next.kind          = ces_pkg::KIND_SUM;
                        out_item_next.list_changed  = pass_changed_reg;
                        out_item_next.flags_changed = item_reg.access_flags != flags_reg;
                        out_item_next.last          = 1'b1;
                        flags_next                  = item_reg.access_flags;
                        pass_changed_next           = 1'b0;
                        sum_pend_next               = 1'b0;
                        state_next                  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            diff_reg         <= '0;
            qry_pend_reg     <= 1'b0;
            sum_pend_reg     <= 1'b0;
            flags_reg        <= '0;
            pass_changed_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            diff_reg         <= diff_next;
            qry_pend_reg     <= qry_pend_next;
            sum_pend_reg     <= sum_pend_next;
            flags_reg        <= flags_next;
            pass_changed_reg <= pass_changed_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        ent_reg      <= ent_next;
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire
